// ----- hdl/ccr_pkg.sv -----
`timescale 1ns / 1ps
package ccr_pkg;

  localparam int ADDR_W = 32;            // block number width
  localparam int SLOT_W = 8;             // reported slot field width
  localparam int CFG_W  = 9;             // slots_in_use register width
  localparam int APB_AW = 3;             // byte address, one 32-bit register
  localparam int APB_DW = 32;

  // register index as decoded from paddr[2]
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 9'd256;

endpackage

// ----- hdl/clock_cache_replacement_top.sv -----
`timescale 1ns / 1ps
// Fully associative block cache tag array with CLOCK (second chance) replacement.
//
// Request channel: drive block_address and raise start; the beat is taken at
// the edge where start is high and busy is low. busy stays high until the
// result is out. Result channel: done pulses for one cycle with hit, slot,
// evicted_valid and evicted_block; the receiver cannot stall, so capture the
// beat in that cycle. A new request may be started in the done cycle.
//
// Scan: the tag RAM has one read port and is scanned one slot per cycle; a hit
// at slot k ends the scan there, while a miss reads all active slots, active
// being the slots filled and in use (256 at most by default). A miss on a full
// cache adds the hand sweep: each set reference bit met (at most active) is
// cleared and skipped, then the victim is read and replaced.
//
// Reset clears the reference bits, the fill count and the hand, and sets
// slots_in_use to 256. No RAM clearing pass: only filled slots are ever read.
// Write slots_in_use over the APB port only while busy is low.
module clock_cache_replacement_top #(
  parameter int CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ccr_pkg::ADDR_W-1:0]    block_address,
  output logic                          done,
  output logic                          hit,
  output logic [ccr_pkg::SLOT_W-1:0]    slot,
  output logic                          evicted_valid,
  output logic [ccr_pkg::ADDR_W-1:0]    evicted_block,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccr_pkg::APB_AW-1:0]    paddr,
  input  logic [ccr_pkg::APB_DW-1:0]    pwdata,
  output logic [ccr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import ccr_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // slot index width
  localparam int CW = $clog2(CAPACITY + 1);                    // slot count width
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;               // clamp compare width

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SWEEP,
    S_EVICT
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    slots_in_use;
  logic [ADDR_W-1:0]   addr_q;
  logic [CW-1:0]       active;
  logic                full;
  logic [CW-1:0]       ridx;
  logic                cmp_valid;
  logic [IW-1:0]       cmp_idx;
  logic [CW-1:0]       filled_count;
  logic [IW-1:0]       hand;
  logic [IW-1:0]       h;
  logic [CAPACITY-1:0] ref_bits;

  logic [EW-1:0]       eff_ext;
  logic [CW-1:0]       eff;
  logic [CW-1:0]       active_c;
  logic                accept;
  logic                cfg_write;
  logic                issue;
  logic                match;
  logic                scan_end;
  logic [IW-1:0]       h_start;
  logic [IW-1:0]       h_next;
  logic [IW-1:0]       hand_wrapped;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [IW-1:0]       ram_raddr;
  logic [ADDR_W-1:0]   ram_rdata;

  // ---------------------------------------------------------------------------
  // Configuration port: one register, always ready, no wait states.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_SLOTS_IN_USE) ? APB_DW'(slots_in_use) : '0;

  // Effective slot count: zero acts as one, anything above capacity as capacity.
  always_comb begin
    eff_ext = EW'(slots_in_use);
    if (slots_in_use == '0) begin
      eff_ext = EW'(1);
    end else if (eff_ext > EW'(CAPACITY)) begin
      eff_ext = EW'(CAPACITY);
    end
    eff      = eff_ext[CW-1:0];
    active_c = (filled_count < eff) ? filled_count : eff;
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Tag scan: issue one RAM read per cycle, compare the previous read's data.
  assign issue    = (state == S_SEARCH) && (ridx < active);
  assign match    = cmp_valid && (ram_rdata == addr_q);
  assign scan_end = (state == S_SEARCH) && !issue && !cmp_valid;

  // Hand restarts at slot 0 if it lies outside the slots in use; wrap on advance.
  assign hand_wrapped = (CW'(hand) >= active) ? '0 : hand;
  assign h_start      = hand_wrapped;
  assign h_next       = ((CW'(h) + CW'(1)) >= active) ? '0 : IW'(CW'(h) + CW'(1));

  // Single tag RAM: read for the scan or the victim, write for fill or replace.
  always_comb begin
    ram_raddr = (state == S_SWEEP) ? h : ridx[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = h;
    if (scan_end && !full) begin
      ram_we    = 1'b1;
      ram_waddr = filled_count[IW-1:0];
    end else if (state == S_EVICT) begin
      ram_we    = 1'b1;
      ram_waddr = h;
    end
  end

  ccr_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (CAPACITY)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (addr_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer, replacement state and registered result.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slots_in_use <= SLOTS_IN_USE_RESET;
      filled_count <= '0;
      hand         <= '0;
      ref_bits     <= '0;
      cmp_valid    <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write && (paddr[2] == REG_SLOTS_IN_USE)) begin
        slots_in_use <= pwdata[CFG_W-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            addr_q    <= block_address;
            active    <= active_c;
            full      <= !(filled_count < eff);
            ridx      <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // advance the read pointer; the compare stage trails it by one registered read
          cmp_valid <= issue;
          cmp_idx   <= ridx[IW-1:0];
          if (issue) begin
            ridx <= ridx + CW'(1);
          end
          if (match) begin
            ref_bits[cmp_idx] <= 1'b1;
            hit           <= 1'b1;
            slot          <= SLOT_W'(cmp_idx);
            evicted_valid <= 1'b0;
            evicted_block <= '0;
            done          <= 1'b1;
            cmp_valid     <= 1'b0;
            state         <= S_IDLE;
          end else if (scan_end) begin
            if (!full) begin
              // fill the next free slot
              ref_bits[filled_count[IW-1:0]] <= 1'b1;
              filled_count  <= filled_count + CW'(1);
              hit           <= 1'b0;
              slot          <= SLOT_W'(filled_count[IW-1:0]);
              evicted_valid <= 1'b0;
              evicted_block <= '0;
              done          <= 1'b1;
              state         <= S_IDLE;
            end else begin
              h     <= h_start;
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          // give referenced slots a second chance, stop at the first clear bit
          if (ref_bits[h]) begin
            ref_bits[h] <= 1'b0;
            h           <= h_next;
          end else begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          ref_bits[h]   <= 1'b1;
          hand          <= h_next;
          hit           <= 1'b0;
          slot          <= SLOT_W'(h);
          evicted_valid <= 1'b1;
          evicted_block <= ram_rdata;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> !hit)
    else $error("eviction reported on a hit");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (CW'(h) < active))
    else $error("hand outside the slots in use");

endmodule

// ----- hdl/ccr_ram.sv -----
`timescale 1ns / 1ps
module ccr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
